// ===== sv/clw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clw_pkg
// Shared types, codes and constant tables for the character LCD write
// sequencer: job kinds, segment descriptors, init program and glyph map.
// ----------------------------------------------------------------------------
package clw_pkg;

    // job kinds as carried on the input channel
    localparam logic [2:0] KIND_INIT   = 3'd0;
    localparam logic [2:0] KIND_CMD    = 3'd1;
    localparam logic [2:0] KIND_CHAR   = 3'd2;
    localparam logic [2:0] KIND_CURSOR = 3'd3;
    localparam logic [2:0] KIND_CLEAR  = 3'd4;

    // segment operations of the sequencer program
    localparam logic [1:0] SEG_DELAY = 2'd0;
    localparam logic [1:0] SEG_NIB   = 2'd1;
    localparam logic [1:0] SEG_BYTE  = 2'd2;

    // hold times in ms
    localparam logic [7:0] HOLD_POWER = 8'd200;
    localparam logic [7:0] HOLD_WAKE1 = 8'd50;
    localparam logic [7:0] HOLD_WAKE  = 8'd10;
    localparam logic [7:0] HOLD_NIB   = 8'd5;
    localparam logic [7:0] HOLD_PRE   = 8'd1;

    // controller command bytes
    localparam logic [7:0] LCD_FUNC_SET  = 8'h28;
    localparam logic [7:0] LCD_DISP_ON   = 8'h0C;
    localparam logic [7:0] LCD_CLR_DISP  = 8'h01;
    localparam logic [7:0] LCD_ENTRY     = 8'h06;
    localparam logic [7:0] LCD_DDRAM     = 8'h80;
    localparam logic [7:0] LCD_HOME      = 8'h02;
    localparam logic [3:0] LCD_WAKE_NIB  = 4'h3;
    localparam logic [3:0] LCD_MODE4_NIB = 4'h2;

    // number of segments in each program
    localparam logic [3:0] INIT_SEGS  = 4'd14;
    localparam logic [3:0] CLEAR_SEGS = 4'd2;
    localparam logic [3:0] ONE_SEG    = 4'd1;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] val;
        logic [7:0] hold;
    } seg_t;

    // command from controller to datapath for one result
    typedef struct packed {
        logic       emit;
        logic       drive;
        logic       use_op;
        logic [7:0] const_byte;
        logic       hi_sel;
        logic       en;
        logic [7:0] hold;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    // power-up program
    function automatic seg_t init_seg(input logic [3:0] idx);
        seg_t s;
        s = '{op: SEG_DELAY, val: 8'h00, hold: HOLD_WAKE};
        unique case (idx)
            4'd0:  s = '{op: SEG_DELAY, val: 8'h00, hold: HOLD_POWER};
            4'd1:  s = '{op: SEG_NIB, val: {4'h0, LCD_WAKE_NIB}, hold: HOLD_NIB};
            4'd2:  s = '{op: SEG_DELAY, val: 8'h00, hold: HOLD_WAKE1};
            4'd3:  s = '{op: SEG_NIB, val: {4'h0, LCD_WAKE_NIB}, hold: HOLD_NIB};
            4'd4:  s = '{op: SEG_DELAY, val: 8'h00, hold: HOLD_WAKE};
            4'd5:  s = '{op: SEG_NIB, val: {4'h0, LCD_WAKE_NIB}, hold: HOLD_NIB};
            4'd6:  s = '{op: SEG_DELAY, val: 8'h00, hold: HOLD_WAKE};
            4'd7:  s = '{op: SEG_NIB, val: {4'h0, LCD_MODE4_NIB}, hold: HOLD_NIB};
            4'd8:  s = '{op: SEG_DELAY, val: 8'h00, hold: HOLD_WAKE};
            4'd9:  s = '{op: SEG_BYTE, val: LCD_FUNC_SET, hold: HOLD_PRE};
            4'd10: s = '{op: SEG_BYTE, val: LCD_DISP_ON, hold: HOLD_PRE};
            4'd11: s = '{op: SEG_BYTE, val: LCD_CLR_DISP, hold: HOLD_PRE};
            4'd12: s = '{op: SEG_BYTE, val: LCD_ENTRY, hold: HOLD_PRE};
            4'd13: s = '{op: SEG_BYTE, val: LCD_DDRAM, hold: HOLD_PRE};
            default: s = '{op: SEG_DELAY, val: 8'h00, hold: HOLD_WAKE};
        endcase
        return s;
    endfunction

    // ddram base address of each display line
    function automatic logic [6:0] line_base(input logic [1:0] ln);
        logic [6:0] b;
        b = 7'h00;
        unique case (ln)
            2'd0: b = 7'h00;
            2'd1: b = 7'h40;
            2'd2: b = 7'h14;
            2'd3: b = 7'h54;
            default: b = 7'h00;
        endcase
        return b;
    endfunction

    // cyrillic glyph map for codes 192 and up
    function automatic logic [7:0] cyr_map(input logic [5:0] idx);
        logic [7:0] c;
        c = 8'h00;
        unique case (idx)
            6'd0:  c = 8'h41; 6'd1:  c = 8'hA0; 6'd2:  c = 8'h42; 6'd3:  c = 8'hA1;
            6'd4:  c = 8'hE0; 6'd5:  c = 8'h45; 6'd6:  c = 8'hA3; 6'd7:  c = 8'hA4;
            6'd8:  c = 8'hA5; 6'd9:  c = 8'hA6; 6'd10: c = 8'h4B; 6'd11: c = 8'hA7;
            6'd12: c = 8'h4D; 6'd13: c = 8'h48; 6'd14: c = 8'h4F; 6'd15: c = 8'hA8;
            6'd16: c = 8'h50; 6'd17: c = 8'h43; 6'd18: c = 8'h54; 6'd19: c = 8'hA9;
            6'd20: c = 8'hAA; 6'd21: c = 8'h58; 6'd22: c = 8'hE1; 6'd23: c = 8'hAB;
            6'd24: c = 8'hAC; 6'd25: c = 8'hE2; 6'd26: c = 8'hAD; 6'd27: c = 8'hAE;
            6'd28: c = 8'hAD; 6'd29: c = 8'hAF; 6'd30: c = 8'hB0; 6'd31: c = 8'hB1;
            6'd32: c = 8'h61; 6'd33: c = 8'hB2; 6'd34: c = 8'hB3; 6'd35: c = 8'hB4;
            6'd36: c = 8'hE3; 6'd37: c = 8'h65; 6'd38: c = 8'hB6; 6'd39: c = 8'hB7;
            6'd40: c = 8'hB8; 6'd41: c = 8'hB9; 6'd42: c = 8'hBA; 6'd43: c = 8'hBB;
            6'd44: c = 8'hBC; 6'd45: c = 8'hBD; 6'd46: c = 8'h6F; 6'd47: c = 8'hBE;
            6'd48: c = 8'h70; 6'd49: c = 8'h63; 6'd50: c = 8'hBF; 6'd51: c = 8'h79;
            6'd52: c = 8'hE4; 6'd53: c = 8'h78; 6'd54: c = 8'hE5; 6'd55: c = 8'hC0;
            6'd56: c = 8'hC1; 6'd57: c = 8'hE6; 6'd58: c = 8'hC2; 6'd59: c = 8'hC3;
            6'd60: c = 8'hC4; 6'd61: c = 8'hC5; 6'd62: c = 8'hC6; 6'd63: c = 8'hC7;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== sv/clw_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clw_ctrl
// Sequencer state machine: walks the segment program of the current job and
// issues one pin command per cycle while the output slot is free.
// ----------------------------------------------------------------------------
module clw_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [2:0]      kind,
    input  wire clw_pkg::status_t status,
    output clw_pkg::cmd_t        cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic       state_reg, state_next;
    logic [2:0] job_reg, job_next;
    logic [3:0] seg_reg, seg_next;
    logic [2:0] phase_reg, phase_next;

    clw_pkg::seg_t seg;
    logic [3:0]    seg_count;
    logic          seg_last;
    logic          phase_last;
    logic          accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // current segment of the job program
    always_comb
    begin
        seg       = '{op: clw_pkg::SEG_BYTE, val: 8'h00, hold: clw_pkg::HOLD_PRE};
        seg_count = clw_pkg::ONE_SEG;
        case (job_reg)
            clw_pkg::KIND_INIT:
            begin
                seg       = clw_pkg::init_seg(seg_reg);
                seg_count = clw_pkg::INIT_SEGS;
            end
            clw_pkg::KIND_CLEAR:
            begin
                seg.val   = (seg_reg == 4'd0) ? clw_pkg::LCD_CLR_DISP : clw_pkg::LCD_HOME;
                seg_count = clw_pkg::CLEAR_SEGS;
            end
            default:
            begin
                seg.val   = 8'h00;
                seg_count = clw_pkg::ONE_SEG;
            end
        endcase
    end

    assign seg_last = (seg_reg == seg_count - 4'd1);

    // end of segment and pin command
    always_comb
    begin
        phase_last     = 1'b0;
        cmd            = '0;
        cmd.const_byte = seg.val;
        cmd.use_op     = (job_reg == clw_pkg::KIND_CMD) || (job_reg == clw_pkg::KIND_CHAR)
                         || (job_reg == clw_pkg::KIND_CURSOR);
        unique case (seg.op)
            clw_pkg::SEG_DELAY:
            begin
                phase_last = 1'b1;
                cmd.hold   = seg.hold;
            end
            clw_pkg::SEG_NIB:
            begin
                phase_last = (phase_reg == 3'd2);
                cmd.drive  = 1'b1;
                cmd.hi_sel = 1'b0;
                cmd.en     = (phase_reg == 3'd1);
                cmd.hold   = clw_pkg::HOLD_NIB;
            end
            clw_pkg::SEG_BYTE:
            begin
                phase_last = (phase_reg == 3'd6);
                cmd.drive  = (phase_reg != 3'd0);
                cmd.hi_sel = (phase_reg <= 3'd3);
                cmd.en     = (phase_reg == 3'd2) || (phase_reg == 3'd5);
                cmd.hold   = (phase_reg == 3'd0) ? clw_pkg::HOLD_PRE : clw_pkg::HOLD_NIB;
            end
            default:
            begin
                phase_last = 1'b1;
            end
        endcase
        cmd.emit = (state_reg == ST_RUN) && status.out_free;
        cmd.last = seg_last && phase_last;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        seg_next   = seg_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (kind <= clw_pkg::KIND_CLEAR))
                begin
                    state_next = ST_RUN;
                    job_next   = kind;
                    seg_next   = 4'd0;
                    phase_next = 3'd0;
                end
            end
            ST_RUN:
            begin
                if (cmd.emit)
                begin
                    if (phase_last)
                    begin
                        phase_next = 3'd0;
                        if (seg_last)
                            state_next = ST_IDLE;
                        else
                            seg_next = seg_reg + 4'd1;
                    end
                    else
                    begin
                        phase_next = phase_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            job_reg   <= clw_pkg::KIND_INIT;
            seg_reg   <= 4'd0;
            phase_reg <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
            seg_reg   <= seg_next;
            phase_reg <= phase_next;
        end
    end

`ifndef SYNTHESIS
    // final result of a run returns the sequencer to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && cmd.last |=> state_reg == ST_IDLE)
        else $error("sequencer still running after last result");

    // segment index stays inside the job program
    a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> seg_reg < seg_count)
        else $error("segment index out of range");

    // a command is only issued into a free output slot
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free && state_reg == ST_RUN)
        else $error("command issued without free output slot");
`endif

endmodule
`default_nettype wire

// ===== sv/clw_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clw_datapath
// Operand capture (raw, glyph-mapped or cursor byte), pin level registers and
// the output register of the result channel.
// ----------------------------------------------------------------------------
module clw_datapath (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire logic [2:0]      kind,
    input  wire logic [7:0]      value,
    input  wire logic [6:0]      column,
    input  wire logic [1:0]      line,
    input  wire clw_pkg::cmd_t   cmd,
    output clw_pkg::status_t     status,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic                 rs,
    output logic                 enable,
    output logic [3:0]           data_nibble,
    output logic [7:0]           hold_ms,
    output logic                 last
);

    logic       rs_reg;
    logic       en_reg;
    logic [3:0] nib_reg;
    logic [7:0] op_byte_reg, op_byte_next;
    logic       op_rs_reg;
    logic       out_valid_reg;
    logic [7:0] hold_reg;
    logic       last_reg;

    logic [7:0] src_byte;
    logic [3:0] src_nib;
    logic [6:0] cursor_addr;

    // operand byte for single-byte jobs
    assign cursor_addr = clw_pkg::line_base(line) + column;

    always_comb
    begin
        op_byte_next = value;
        unique case (kind)
            clw_pkg::KIND_CHAR:
            begin
                if (value[7:6] == 2'b11)
                    op_byte_next = clw_pkg::cyr_map(value[5:0]);
                else
                    op_byte_next = value;
            end
            clw_pkg::KIND_CURSOR: op_byte_next = {1'b1, cursor_addr};
            default:              op_byte_next = value;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_byte_reg <= op_byte_next;
            op_rs_reg   <= (kind == clw_pkg::KIND_CHAR);
        end
    end

    // nibble to drive on the bus
    assign src_byte = cmd.use_op ? op_byte_reg : cmd.const_byte;
    assign src_nib  = cmd.hi_sel ? src_byte[7:4] : src_byte[3:0];

    assign status.out_free = !out_valid_reg || out_ready;

    // pin levels, changed only when a transaction is issued
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_reg  <= 1'b0;
            en_reg  <= 1'b0;
            nib_reg <= 4'h0;
        end
        else if (cmd.emit && cmd.drive)
        begin
            rs_reg  <= cmd.use_op & op_rs_reg;
            en_reg  <= cmd.en;
            nib_reg <= src_nib;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            hold_reg <= cmd.hold;
            last_reg <= cmd.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign rs          = rs_reg;
    assign enable      = en_reg;
    assign data_nibble = nib_reg;
    assign hold_ms     = hold_reg;
    assign last        = last_reg;

`ifndef SYNTHESIS
    // a strobe phase always lasts one nibble hold
    a_strobe_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && en_reg |-> hold_reg == clw_pkg::HOLD_NIB)
        else $error("enable high with wrong hold time");
`endif

endmodule
`default_nettype wire

// ===== sv/char_lcd_4bit_write_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_4bit_write_sequencer
// Turns LCD jobs (init, command, character, cursor move, clear) into timed
// runs of RS / E / D4..D7 pin states for a 4-bit character display bus.
// ----------------------------------------------------------------------------
// Each accepted job puts out one pin state per cycle while out_ready stays
// high: 7 results for a command, character or cursor move, 14 for a clear and
// 52 for the init sequence. The sequencer state machine issues one result per
// cycle while the output register is free, into a single output register; a
// new job is taken once the final result of the run (marked by last) has been
// issued. Kinds 5 to 7 are accepted and produce nothing. Each result carries
// hold_ms, the time the pin levels must be held before the next result is
// applied.
module char_lcd_4bit_write_sequencer (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [2:0] kind,
    input  wire logic [7:0] value,
    input  wire logic [6:0] column,
    input  wire logic [1:0] line,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            rs,
    output logic            enable,
    output logic [3:0]      data_nibble,
    output logic [7:0]      hold_ms,
    output logic            last
);

    clw_pkg::cmd_t    cmd;
    clw_pkg::status_t status;
    logic             accept;

    assign accept = in_valid && in_ready;

    // job sequencer
    clw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .status   (status),
        .cmd      (cmd)
    );

    // operand, pin and output registers
    clw_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .kind        (kind),
        .value       (value),
        .column      (column),
        .line        (line),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .rs          (rs),
        .enable      (enable),
        .data_nibble (data_nibble),
        .hold_ms     (hold_ms),
        .last        (last)
    );

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 4-bit character LCD write sequencer. Jobs go in
// over a valid/ready channel: a short table of directed jobs first, then
// random jobs. Every accepted job is turned into its expected run of timed pin
// states by a local model of the bus sequencing, and every pin state that
// comes out is checked field by field against the oldest one still due.
// ----------------------------------------------------------------------------
module testbench;

    // kinds that the block takes and drops
    localparam logic [2:0] KIND_SPARE_LO  = 3'd5;
    localparam logic [2:0] KIND_SPARE_MID = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI  = 3'd7;

    localparam int RANDOM_JOBS   = 150;
    localparam int LONG_HOLD     = 300;
    localparam int TAIL_CYCLES   = 100;
    localparam int STALL_LIMIT   = 3000;
    localparam int REPORT_LIMIT  = 10;

    // glyph codes for character codes 192 and up
    localparam logic [7:0] GLYPH_MAP [0:63] = '{
        8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
        8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
        8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
        8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'hAD, 8'hAF, 8'hB0, 8'hB1,
        8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
        8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
        8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
        8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
    };

    // ddram start address of each display line
    localparam logic [6:0] ROW_START [0:3] = '{7'h00, 7'h40, 7'h14, 7'h54};

    typedef struct packed {
        logic       rs;
        logic       en;
        logic [3:0] nib;
        logic [7:0] hold;
        logic       last;
    } pin_state_t;

    // one directed job; fixed rows carry the byte that must go on the bus
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic [6:0] column;
        logic [1:0] line;
        logic       fixed;
        logic       fixed_rs;
        logic [7:0] fixed_byte;
    } job_row_t;

    typedef struct packed {
        logic       fixed;
        logic       fixed_rs;
        logic [7:0] fixed_byte;
    } job_note_t;

    localparam int DIRECTED_JOBS = 21;
    localparam job_row_t DIRECTED_ROWS [0:DIRECTED_JOBS-1] = '{
        '{clw_pkg::KIND_CMD,    8'h00, 7'h00, 2'd0, 1'b1, 1'b0, 8'h00},
        '{clw_pkg::KIND_CMD,    8'hFF, 7'h7F, 2'd3, 1'b1, 1'b0, 8'hFF},
        '{clw_pkg::KIND_CHAR,   8'h00, 7'h00, 2'd0, 1'b1, 1'b1, 8'h00},
        '{clw_pkg::KIND_CHAR,   8'hBF, 7'h2A, 2'd1, 1'b1, 1'b1, 8'hBF},
        '{clw_pkg::KIND_CHAR,   8'hC0, 7'h00, 2'd0, 1'b1, 1'b1, 8'h41},
        '{clw_pkg::KIND_CHAR,   8'hFF, 7'h7F, 2'd3, 1'b1, 1'b1, 8'hC7},
        '{clw_pkg::KIND_CHAR,   8'hDC, 7'h00, 2'd0, 1'b0, 1'b0, 8'h00},
        '{clw_pkg::KIND_CHAR,   8'h5A, 7'h55, 2'd2, 1'b0, 1'b0, 8'h00},
        '{clw_pkg::KIND_CURSOR, 8'hFF, 7'h00, 2'd0, 1'b1, 1'b0, 8'h80},
        '{clw_pkg::KIND_CURSOR, 8'h00, 7'h7F, 2'd3, 1'b1, 1'b0, 8'hD3},
        '{clw_pkg::KIND_CURSOR, 8'h00, 7'h3F, 2'd1, 1'b1, 1'b0, 8'hFF},
        '{clw_pkg::KIND_CURSOR, 8'hA5, 7'h05, 2'd2, 1'b0, 1'b0, 8'h00},
        '{clw_pkg::KIND_CURSOR, 8'h00, 7'h7F, 2'd1, 1'b0, 1'b0, 8'h00},
        '{clw_pkg::KIND_CLEAR,  8'hFF, 7'h7F, 2'd3, 1'b0, 1'b0, 8'h00},
        '{clw_pkg::KIND_INIT,   8'hFF, 7'h7F, 2'd3, 1'b0, 1'b0, 8'h00},
        '{KIND_SPARE_LO,        8'hFF, 7'h7F, 2'd3, 1'b1, 1'b0, 8'h00},
        '{KIND_SPARE_MID,       8'h00, 7'h00, 2'd0, 1'b1, 1'b0, 8'h00},
        '{KIND_SPARE_HI,        8'hC0, 7'h55, 2'd2, 1'b1, 1'b0, 8'h00},
        '{clw_pkg::KIND_CMD,    8'h5A, 7'h2A, 2'd1, 1'b0, 1'b0, 8'h00},
        '{clw_pkg::KIND_INIT,   8'h00, 7'h00, 2'd0, 1'b0, 1'b0, 8'h00},
        '{clw_pkg::KIND_CHAR,   8'hE6, 7'h11, 2'd0, 1'b0, 1'b0, 8'h00}
    };

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [2:0] kind;
    logic [7:0] value;
    logic [6:0] column;
    logic [1:0] line;
    logic       out_valid;
    logic       out_ready;
    logic       rs;
    logic       enable;
    logic [3:0] data_nibble;
    logic [7:0] hold_ms;
    logic       last;

    // model of the pin levels
    logic       pin_rs;
    logic       pin_en;
    logic [3:0] pin_nib;

    pin_state_t pins_due [$];
    job_note_t  job_notes [$];
    job_note_t  taken_note;
    int         bad_count;
    int         idle_cycles;
    int         long_hold_asks;
    int         long_hold_done;
    int         ready_stall;
    logic       calm;

    char_lcd_4bit_write_sequencer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .value       (value),
        .column      (column),
        .line        (line),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .rs          (rs),
        .enable      (enable),
        .data_nibble (data_nibble),
        .hold_ms     (hold_ms),
        .last        (last)
    );

    always #2 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // expected pin states
    task automatic hold_pins(input logic [7:0] hold);
        pins_due.push_back('{pin_rs, pin_en, pin_nib, hold, 1'b0});
    endtask

    task automatic strobe_nibble(input logic [3:0] nib);
        pin_nib = nib;
        pin_en  = 1'b0;
        hold_pins(clw_pkg::HOLD_NIB);
        pin_en  = 1'b1;
        hold_pins(clw_pkg::HOLD_NIB);
        pin_en  = 1'b0;
        hold_pins(clw_pkg::HOLD_NIB);
    endtask

    task automatic write_bus_byte(input logic reg_sel, input logic [7:0] b);
        hold_pins(clw_pkg::HOLD_PRE);
        pin_rs = reg_sel;
        strobe_nibble(b[7:4]);
        strobe_nibble(b[3:0]);
    endtask

    task automatic close_run(input int first);
        if (pins_due.size() > first)
            pins_due[pins_due.size() - 1].last = 1'b1;
    endtask

    // expected run of pin states for one job
    task automatic predict_lcd_job(input logic [2:0] k, input logic [7:0] v,
                                   input logic [6:0] col, input logic [1:0] ln);
        int         first;
        logic [6:0] addr;
        first = pins_due.size();
        case (k)
            clw_pkg::KIND_INIT:
            begin
                hold_pins(clw_pkg::HOLD_POWER);
                pin_rs = 1'b0;
                strobe_nibble(clw_pkg::LCD_WAKE_NIB);
                hold_pins(clw_pkg::HOLD_WAKE1);
                strobe_nibble(clw_pkg::LCD_WAKE_NIB);
                hold_pins(clw_pkg::HOLD_WAKE);
                strobe_nibble(clw_pkg::LCD_WAKE_NIB);
                hold_pins(clw_pkg::HOLD_WAKE);
                strobe_nibble(clw_pkg::LCD_MODE4_NIB);
                hold_pins(clw_pkg::HOLD_WAKE);
                write_bus_byte(1'b0, clw_pkg::LCD_FUNC_SET);
                write_bus_byte(1'b0, clw_pkg::LCD_DISP_ON);
                write_bus_byte(1'b0, clw_pkg::LCD_CLR_DISP);
                write_bus_byte(1'b0, clw_pkg::LCD_ENTRY);
                write_bus_byte(1'b0, clw_pkg::LCD_DDRAM);
            end
            clw_pkg::KIND_CMD:
                write_bus_byte(1'b0, v);
            clw_pkg::KIND_CHAR:
                write_bus_byte(1'b1, (v >= 8'd192) ? GLYPH_MAP[v[5:0]] : v);
            clw_pkg::KIND_CURSOR:
            begin
                addr = ROW_START[ln] + col;
                write_bus_byte(1'b0, clw_pkg::LCD_DDRAM | {1'b0, addr});
            end
            clw_pkg::KIND_CLEAR:
            begin
                write_bus_byte(1'b0, clw_pkg::LCD_CLR_DISP);
                write_bus_byte(1'b0, clw_pkg::LCD_HOME);
            end
            default:
                ;
        endcase
        close_run(first);
    endtask

    // compare one pin state against the oldest one due
    task automatic check_pin_state();
        pin_state_t want;
        pin_state_t got;
        got = '{rs, enable, data_nibble, hold_ms, last};
        if (pins_due.size() == 0)
        begin
            bad_count++;
            if (bad_count <= REPORT_LIMIT)
                $display("unexpected pin state rs=%0d e=%0d d=%h hold=%0d last=%0d",
                         got.rs, got.en, got.nib, got.hold, got.last);
        end
        else
        begin
            want = pins_due.pop_front();
            if (want.rs !== got.rs || want.en !== got.en || want.nib !== got.nib ||
                want.hold !== got.hold || want.last !== got.last)
            begin
                bad_count++;
                if (bad_count <= REPORT_LIMIT)
                    $display("pin state mismatch: exp rs=%0d e=%0d d=%h hold=%0d last=%0d, %s",
                             want.rs, want.en, want.nib, want.hold, want.last,
                             $sformatf("got rs=%0d e=%0d d=%h hold=%0d last=%0d",
                                       got.rs, got.en, got.nib, got.hold, got.last));
            end
        end
    endtask

    // transaction monitor on both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            idle_cycles++;
            if (out_valid && out_ready)
            begin
                idle_cycles = 0;
                check_pin_state();
            end
            if (in_valid && in_ready)
            begin
                idle_cycles = 0;
                taken_note = job_notes.pop_front();
                if (!taken_note.fixed)
                    predict_lcd_job(kind, value, column, line);
                else if (kind inside {clw_pkg::KIND_CMD, clw_pkg::KIND_CHAR,
                                      clw_pkg::KIND_CURSOR})
                begin
                    write_bus_byte(taken_note.fixed_rs, taken_note.fixed_byte);
                    close_run(pins_due.size() - 7);
                end
            end
        end
    end

    // receiver with random stalls and an occasional long hold-off
    always @(negedge clk)
    begin
        if (long_hold_asks != long_hold_done)
        begin
            long_hold_done = long_hold_asks;
            ready_stall = LONG_HOLD;
        end
        if (ready_stall > 0)
        begin
            out_ready <= 1'b0;
            ready_stall--;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
                ready_stall = pick_gap();
        end
    end

    // offer one job and wait for its transaction
    task automatic send_job(input job_row_t row);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        job_notes.push_back('{row.fixed, row.fixed_rs, row.fixed_byte});
        kind     <= row.kind;
        value    <= row.value;
        column   <= row.column;
        line     <= row.line;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (pins_due.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic job_row_t random_job();
        job_row_t   row;
        int         r;
        row.value      = 8'($urandom());
        row.column     = 7'($urandom());
        row.line       = 2'($urandom());
        row.fixed      = 1'b0;
        row.fixed_rs   = 1'b0;
        row.fixed_byte = 8'h00;
        r = $urandom_range(0, 99);
        if (r < 4)
            row.kind = clw_pkg::KIND_INIT;
        else if (r < 28)
            row.kind = clw_pkg::KIND_CMD;
        else if (r < 58)
        begin
            row.kind = clw_pkg::KIND_CHAR;
            // half the characters are forced into the glyph map range
            if (r < 43)
                row.value[7:6] = 2'b11;
        end
        else if (r < 80)
            row.kind = clw_pkg::KIND_CURSOR;
        else if (r < 92)
            row.kind = clw_pkg::KIND_CLEAR;
        else
            row.kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
        return row;
    endfunction

    // stimulus and end of run
    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        kind           = clw_pkg::KIND_INIT;
        value          = 8'h00;
        column         = 7'h00;
        line           = 2'd0;
        out_ready      = 1'b0;
        pin_rs         = 1'b0;
        pin_en         = 1'b0;
        pin_nib        = 4'h0;
        bad_count      = 0;
        idle_cycles    = 0;
        long_hold_asks = 0;
        long_hold_done = 0;
        ready_stall    = 0;
        calm           = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIRECTED_JOBS; i++)
            send_job(DIRECTED_ROWS[i]);
        wait_for_drain();

        for (int i = 0; i < RANDOM_JOBS; i++)
        begin
            // receiver holds off while jobs keep coming
            if (i == 20)
                long_hold_asks <= long_hold_asks + 1;
            // stretch with no idling on either side
            if (i == 60)
                calm <= 1'b1;
            if (i == 90)
                calm <= 1'b0;
            if (i == 110)
                wait_for_drain();
            send_job(random_job());
        end
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (bad_count == 0 && pins_due.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // watchdog on cycles with no transaction
    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("testbench: done, errors");
        $finish;
    end

endmodule
